@@ hw/rtl/nfps_pkg.sv @@
// Package for the nearest/farthest point select block.
// Holds widths, the configuration register codes, the stage control struct and the
// coordinate biasing function. No dependencies.
package nfps_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 24;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MIND_W     = 24;
  localparam int BSQ_W      = 2 * MIND_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = SQ_W + 2;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_ENABLE = 2'd0,
    CFG_MIN_DISTANCE     = 2'd1
  } nfps_cfg_idx_t;

  typedef logic [COORD_BITS-1:0] nfps_coord_t;
  typedef logic [2:0][COORD_BITS-1:0] nfps_vec_t;
  typedef logic [2:0][SQ_W-1:0] nfps_sq_vec_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             mode;
    logic             unb_first;
    logic             pt_ok;
    logic [IDX_W-1:0] idx;
  } nfps_ctl_t;

  // Signed coordinate to offset binary, so that differences are taken as unsigned subtraction.
  function automatic nfps_coord_t to_biased(input logic [COORD_BITS-1:0] v);
    return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
  endfunction

endpackage

@@ hw/rtl/nfps_front.sv @@
// Input stage: configuration registers, run tracking, point counter and the
// input register. Depends on nfps_pkg.
module nfps_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic                                 in_mode,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_x,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_y,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_z,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_x,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_y,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_z,
  input  logic                                 in_last_point,
  input  logic                                 cfg_valid,
  input  logic [nfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nfps_pkg::MIND_W-1:0]          cfg_data,
  output logic                                 s1_valid,
  output nfps_pkg::nfps_ctl_t                  s1_ctl,
  output nfps_pkg::nfps_vec_t                  s1_pt,
  output nfps_pkg::nfps_vec_t                  s1_qr,
  output logic [nfps_pkg::MIND_W-1:0]          s1_bnd
);

  logic                            thr_en_r;
  logic [nfps_pkg::MIND_W-1:0]     min_dist_r;
  logic                            run_active_r, run_active_nxt;
  logic                            mode_r;
  logic [nfps_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  nfps_pkg::nfps_vec_t             query_r;
  logic                            s1_valid_r;
  nfps_pkg::nfps_ctl_t             s1_ctl_r, s1_ctl_nxt;
  nfps_pkg::nfps_vec_t             s1_pt_r, s1_pt_nxt;
  nfps_pkg::nfps_vec_t             s1_qr_r, s1_qr_nxt;
  logic [nfps_pkg::MIND_W-1:0]     s1_bnd_r, s1_bnd_nxt;
  logic                            acc;
  logic                            first;
  logic                            mode_eff;
  logic [nfps_pkg::CNT_W-1:0]      idx_cur;
  logic                            pt_ok;
  nfps_pkg::nfps_vec_t             in_qr_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_en_r   <= 1'b0;
      min_dist_r <= '0;
    end else if (cfg_valid) begin
      unique case (nfps_pkg::nfps_cfg_idx_t'(cfg_index))
        nfps_pkg::CFG_THRESHOLD_ENABLE: thr_en_r <= cfg_data[0];
        nfps_pkg::CFG_MIN_DISTANCE:     min_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc      = in_valid && adv;
    first    = !run_active_r;
    mode_eff = first ? in_mode : mode_r;
    idx_cur  = first ? '0 : cnt_r;
    pt_ok    = idx_cur < nfps_pkg::CNT_W'(nfps_pkg::MAX_POINTS);
    in_qr_b[0] = nfps_pkg::to_biased(in_query_x);
    in_qr_b[1] = nfps_pkg::to_biased(in_query_y);
    in_qr_b[2] = nfps_pkg::to_biased(in_query_z);
    run_active_nxt = acc ? !in_last_point : run_active_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      cnt_nxt = pt_ok ? idx_cur + 1'b1 : idx_cur;
    end
    s1_ctl_nxt.first     = first;
    s1_ctl_nxt.last      = in_last_point;
    s1_ctl_nxt.mode      = mode_eff;
    s1_ctl_nxt.unb_first = first && !in_mode && !thr_en_r;
    s1_ctl_nxt.pt_ok     = pt_ok;
    s1_ctl_nxt.idx       = idx_cur[nfps_pkg::IDX_W-1:0];
    s1_pt_nxt[0] = nfps_pkg::to_biased(in_point_x);
    s1_pt_nxt[1] = nfps_pkg::to_biased(in_point_y);
    s1_pt_nxt[2] = nfps_pkg::to_biased(in_point_z);
    s1_qr_nxt    = first ? in_qr_b : query_r;
    s1_bnd_nxt   = thr_en_r ? min_dist_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      mode_r       <= 1'b0;
      cnt_r        <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      run_active_r <= run_active_nxt;
      cnt_r        <= cnt_nxt;
      if (acc && first) begin
        mode_r <= in_mode;
      end
      if (adv) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && first) begin
      query_r <= in_qr_b;
    end
    if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_pt_r  <= s1_pt_nxt;
      s1_qr_r  <= s1_qr_nxt;
      s1_bnd_r <= s1_bnd_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_ctl   = s1_ctl_r;
  assign s1_pt    = s1_pt_r;
  assign s1_qr    = s1_qr_r;
  assign s1_bnd   = s1_bnd_r;

endmodule

@@ hw/rtl/nfps_dist.sv @@
// Squared distance pipeline: axis differences, squares, then the sum, one
// register stage each. The threshold is squared alongside. Depends on nfps_pkg.
module nfps_dist (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 s1_valid,
  input  nfps_pkg::nfps_ctl_t                  s1_ctl,
  input  nfps_pkg::nfps_vec_t                  s1_pt,
  input  nfps_pkg::nfps_vec_t                  s1_qr,
  input  logic [nfps_pkg::MIND_W-1:0]          s1_bnd,
  output logic                                 s4_valid,
  output nfps_pkg::nfps_ctl_t                  s4_ctl,
  output logic [nfps_pkg::DIST_W-1:0]          s4_dist,
  output logic [nfps_pkg::BSQ_W-1:0]           s4_bsq
);

  logic                                s2_valid_r, s3_valid_r, s4_valid_r;
  nfps_pkg::nfps_ctl_t                 s2_ctl_r, s3_ctl_r, s4_ctl_r;
  nfps_pkg::nfps_vec_t                 s2_mag_r, s2_mag_nxt;
  logic [nfps_pkg::MIND_W-1:0]         s2_bnd_r;
  nfps_pkg::nfps_sq_vec_t              s3_sq_r, s3_sq_nxt;
  logic [nfps_pkg::BSQ_W-1:0]          s3_bsq_r, s3_bsq_nxt;
  logic [nfps_pkg::DIST_W-1:0]         s4_dist_r, s4_dist_nxt;
  logic [nfps_pkg::BSQ_W-1:0]          s4_bsq_r;
  logic [nfps_pkg::COORD_BITS:0]       diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff = {1'b0, s1_pt[i]} - {1'b0, s1_qr[i]};
      s2_mag_nxt[i] = diff[nfps_pkg::COORD_BITS] ? nfps_pkg::COORD_BITS'(-diff)
                                                 : diff[nfps_pkg::COORD_BITS-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      s3_sq_nxt[i] = nfps_pkg::SQ_W'(s2_mag_r[i]) * nfps_pkg::SQ_W'(s2_mag_r[i]);
    end
    s3_bsq_nxt  = nfps_pkg::BSQ_W'(s2_bnd_r) * nfps_pkg::BSQ_W'(s2_bnd_r);
    s4_dist_nxt = nfps_pkg::DIST_W'(s3_sq_r[0]) + nfps_pkg::DIST_W'(s3_sq_r[1])
                + nfps_pkg::DIST_W'(s3_sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r  <= s1_ctl;
      s2_mag_r  <= s2_mag_nxt;
      s2_bnd_r  <= s1_bnd;
      s3_ctl_r  <= s2_ctl_r;
      s3_sq_r   <= s3_sq_nxt;
      s3_bsq_r  <= s3_bsq_nxt;
      s4_ctl_r  <= s3_ctl_r;
      s4_dist_r <= s4_dist_nxt;
      s4_bsq_r  <= s3_bsq_r;
    end
  end

  assign s4_valid = s4_valid_r;
  assign s4_ctl   = s4_ctl_r;
  assign s4_dist  = s4_dist_r;
  assign s4_bsq   = s4_bsq_r;

endmodule

@@ hw/rtl/nfps_track.sv @@
// Running best and farthest trackers and the result register.
// Depends on nfps_pkg.
module nfps_track (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 s4_valid,
  input  nfps_pkg::nfps_ctl_t                  s4_ctl,
  input  logic [nfps_pkg::DIST_W-1:0]          s4_dist,
  input  logic [nfps_pkg::BSQ_W-1:0]           s4_bsq,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [nfps_pkg::IDX_W-1:0]           out_chosen_index,
  output logic                                 out_fell_back
);

  logic [nfps_pkg::DIST_W-1:0]  best_sq_r, best_sq_nxt;
  logic [nfps_pkg::IDX_W-1:0]   best_slot_r, best_slot_nxt;
  logic                         best_found_r, best_found_nxt;
  logic [nfps_pkg::DIST_W-1:0]  far_sq_r, far_sq_nxt;
  logic [nfps_pkg::IDX_W-1:0]   far_slot_r, far_slot_nxt;
  logic                         out_valid_r;
  logic [nfps_pkg::IDX_W-1:0]   out_idx_r;
  logic                         out_fb_r;
  logic                         take;
  logic                         qual;

  always_comb begin
    take           = adv && s4_valid;
    best_sq_nxt    = best_sq_r;
    best_slot_nxt  = best_slot_r;
    best_found_nxt = best_found_r;
    far_sq_nxt     = far_sq_r;
    far_slot_nxt   = far_slot_r;
    if (s4_ctl.first) begin
      best_sq_nxt    = nfps_pkg::DIST_W'(s4_bsq);
      best_slot_nxt  = '0;
      best_found_nxt = 1'b0;
      far_sq_nxt     = '0;
      far_slot_nxt   = '0;
    end
    if (s4_ctl.mode) begin
      qual = s4_dist > best_sq_nxt;
    end else begin
      qual = s4_ctl.unb_first || (s4_dist < best_sq_nxt);
    end
    if (s4_ctl.pt_ok) begin
      if (qual) begin
        best_sq_nxt    = s4_dist;
        best_slot_nxt  = s4_ctl.idx;
        best_found_nxt = 1'b1;
      end
      if (s4_dist > far_sq_nxt) begin
        far_sq_nxt   = s4_dist;
        far_slot_nxt = s4_ctl.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        best_found_r <= best_found_nxt;
      end
      if (take && s4_ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_sq_r   <= best_sq_nxt;
      best_slot_r <= best_slot_nxt;
      far_sq_r    <= far_sq_nxt;
      far_slot_r  <= far_slot_nxt;
    end
    if (take && s4_ctl.last) begin
      out_idx_r <= best_found_nxt ? best_slot_nxt : far_slot_nxt;
      out_fb_r  <= !best_found_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_fell_back    = out_fb_r;

endmodule

@@ hw/rtl/nearest_farthest_point_select_top.sv @@
// Top level of the nearest/farthest point select block.
// Instantiates nfps_front, nfps_dist and nfps_track; depends on nfps_pkg.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode, point xyz, query xyz, last_point
//   out      out_valid / out_ready  chosen_index, fell_back
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One point is taken every cycle while the pipeline is not stalled. A result
// is registered after the transfer of the point that closes the run, through
// the five register stages (input, difference, square, sum, tracker).
// Reset is synchronous and clears all control state; the block is ready on
// the first cycle after reset. The pipeline stalls only when a run result
// reaches the tracker while the previous result has not been transferred.
module nearest_farthest_point_select_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_x,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_y,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_point_z,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_x,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_y,
  input  logic [nfps_pkg::COORD_BITS-1:0]      in_query_z,
  input  logic                                 in_last_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nfps_pkg::IDX_W-1:0]           out_chosen_index,
  output logic                                 out_fell_back,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nfps_pkg::MIND_W-1:0]          cfg_data
);

  logic                          adv;
  logic                          s1_valid;
  nfps_pkg::nfps_ctl_t           s1_ctl;
  nfps_pkg::nfps_vec_t           s1_pt;
  nfps_pkg::nfps_vec_t           s1_qr;
  logic [nfps_pkg::MIND_W-1:0]   s1_bnd;
  logic                          s4_valid;
  nfps_pkg::nfps_ctl_t           s4_ctl;
  logic [nfps_pkg::DIST_W-1:0]   s4_dist;
  logic [nfps_pkg::BSQ_W-1:0]    s4_bsq;

  assign adv       = !(s4_valid && s4_ctl.last && out_valid && !out_ready);
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  nfps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_mode       (in_mode),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_query_x    (in_query_x),
    .in_query_y    (in_query_y),
    .in_query_z    (in_query_z),
    .in_last_point (in_last_point),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s1_valid      (s1_valid),
    .s1_ctl        (s1_ctl),
    .s1_pt         (s1_pt),
    .s1_qr         (s1_qr),
    .s1_bnd        (s1_bnd)
  );

  nfps_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_pt    (s1_pt),
    .s1_qr    (s1_qr),
    .s1_bnd   (s1_bnd),
    .s4_valid (s4_valid),
    .s4_ctl   (s4_ctl),
    .s4_dist  (s4_dist),
    .s4_bsq   (s4_bsq)
  );

  nfps_track u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .s4_valid         (s4_valid),
    .s4_ctl           (s4_ctl),
    .s4_dist          (s4_dist),
    .s4_bsq           (s4_bsq),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_chosen_index (out_chosen_index),
    .out_fell_back    (out_fell_back)
  );

endmodule
